// ----- hw/rtl/ecq_pkg.sv -----
// ----------------------------------------------------------------------------
// ecq_pkg: shared types and constants of the EC-QMMF site update
// Command, status and register codes, the divider request and response
// structs, the sequencer states and the fixed-point clamp helpers.
// ----------------------------------------------------------------------------
package ecq_pkg;

  // Default sizes, overridable on the top level
  localparam int MAX_SITES_DEF     = 4096;
  localparam int MAX_CLASSES_DEF   = 8;
  localparam int MAX_NEIGHBORS_DEF = 32;

  // Stream and register widths fixed by the item layout
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 32;
  localparam int CMD_W     = 3;
  localparam int SITE_W    = 12;
  localparam int CLS_W     = 3;
  localparam int PROB_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int STS_W     = 2;

  // Divider and fixed-point formats
  localparam int DIV_W = 64;
  localparam int FRAC  = 22;
  localparam logic signed [DIV_W-1:0] SAT_LIM   = 64'sh0000_0100_0000_0000;
  localparam logic signed [DIV_W-1:0] ONE_Q22   = 64'sh0000_0000_0040_0000;
  localparam logic signed [DIV_W-1:0] ONE_Q38   = 64'sh0000_0040_0000_0000;
  localparam logic signed [DIV_W-1:0] Q15_ONE_W = 64'sh0000_0000_0000_8000;
  localparam logic [PROB_W-1:0]       Q15_ONE   = 16'h8000;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NEIGHBOR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COST     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UPDATE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

  // Status codes
  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_NO_NB     = 2'd1;
  localparam logic [STS_W-1:0] STS_ZERO_DEN  = 2'd2;
  localparam logic [STS_W-1:0] STS_ZERO_NORM = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MU     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] dividend;
    logic signed [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_READ_RD, S_READ_OUT, S_NB_RD, S_NB_ACC,
    S_UP_LC, S_UP_LC2, S_UP_MUL, S_UP_N16,
    S_A_DIV, S_A_WAIT, S_B_DIV, S_B_WAIT, S_M_DIV, S_M_WAIT,
    S_P_DIV, S_P_WAIT, S_Q_DIV, S_Q_WAIT, S_Q_OUT,
    S_STAT_OUT, S_CLEAR
  } state_t;

  // Clamp to +-2^40
  function automatic logic signed [DIV_W-1:0] sat40(input logic signed [DIV_W-1:0] v);
    if (v < -SAT_LIM) return -SAT_LIM;
    else if (v > SAT_LIM) return SAT_LIM;
    else return v;
  endfunction

  // Clamp to [0, 1.0] in Q1.15
  function automatic logic [PROB_W-1:0] clip_prob(input logic signed [DIV_W-1:0] v);
    if (v < 0) return '0;
    else if (v > Q15_ONE_W) return Q15_ONE;
    else return v[PROB_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/ecqmmf_node_update.sv -----
// Load and set cost complete in the idle state; add neighbor reads and sums
// the neighbor's value of each class; read fetches the entry, then sends it;
// update runs its divisions in turn on the shared divider; results can stall.
// Throughput: one command at a time; the block is not ready until it finishes.
// Reset clears sums, costs and neighbor count, sets registers to defaults;
// the probability store has no clearing pass; an entry reads undefined until written.
// ----------------------------------------------------------------------------
// ecqmmf_node_update: EC-QMMF Gauss-Seidel site update
// Sequencer around a probability RAM, one shared multiplier and one shared
// divider; computes, clips and normalizes the class probabilities of a site.
// ----------------------------------------------------------------------------
module ecqmmf_node_update #(
  parameter int MAX_SITES     = ecq_pkg::MAX_SITES_DEF,
  parameter int MAX_CLASSES   = ecq_pkg::MAX_CLASSES_DEF,
  parameter int MAX_NEIGHBORS = ecq_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ecq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ecq_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // site[11:0], class_index[14:12], neighbor_site[26:15],
  // prob_value[42:27], cost_value[74:43], zero[79:75]
  input  logic [ecq_pkg::S_TDATA_W-1:0] s_tdata,
  // cmd[2:0]
  input  logic [ecq_pkg::CMD_W-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_site[11:0], out_class[14:12], probability[30:15], zero[31]
  output logic [ecq_pkg::M_TDATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [ecq_pkg::STS_W-1:0]     m_tuser,
  output logic                          m_tlast
);
  import ecq_pkg::*;

  localparam int DEPTH  = MAX_SITES * MAX_CLASSES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int K_W    = $clog2(MAX_CLASSES);
  localparam int CNT_W  = $clog2(MAX_CLASSES + 1);
  localparam int NB_W   = $clog2(MAX_NEIGHBORS + 1);
  localparam int SUM_W  = PROB_W + NB_W;
  localparam int PROD_W = CFG_W + SUM_W;
  localparam int N16_W  = PROD_W - 15;
  localparam logic [ADDR_W-1:0] MC_A = ADDR_W'(MAX_CLASSES);

  // Input field unpacking
  logic [CMD_W-1:0]  in_cmd;
  logic [SITE_W-1:0] in_site;
  logic [CLS_W-1:0]  in_cls;
  logic [SITE_W-1:0] in_nb;
  logic [PROB_W-1:0] in_prob;
  logic [CFG_W-1:0]  in_cost;
  assign in_cmd  = s_tuser;
  assign in_site = s_tdata[11:0];
  assign in_cls  = s_tdata[14:12];
  assign in_nb   = s_tdata[26:15];
  assign in_prob = s_tdata[42:27];
  assign in_cost = s_tdata[74:43];

  state_t state, state_next;

  logic [CFG_W-1:0]        lambda_gain;
  logic signed [CFG_W-1:0] entropy_mu;
  logic [3:0]              class_count;

  logic [SITE_W-1:0] it_site;
  logic [CLS_W-1:0]  it_cls;
  logic [SITE_W-1:0] it_nb;
  logic              rd_zero;
  logic [STS_W-1:0]  status_r;
  logic [K_W-1:0]    k;
  logic [NB_W-1:0]   nb_total;

  logic [SUM_W-1:0]        sums  [MAX_CLASSES];
  logic [CFG_W-1:0]        costs [MAX_CLASSES];
  logic [N16_W-1:0]        n16   [MAX_CLASSES];
  logic signed [DIV_W-1:0] den   [MAX_CLASSES];
  logic [PROB_W-1:0]       p     [MAX_CLASSES];

  logic [PROD_W-1:0]       prod;
  logic [SUM_W-1:0]        mul_b;
  logic [PROD_W-1:0]       lc;
  logic                    bad;
  logic signed [DIV_W-1:0] sa, sb, m;
  logic [CFG_W-1:0]        norm;
  logic [PROB_W-1:0]       qv;

  logic [PROB_W-1:0] out_prob;
  logic [CLS_W-1:0]  out_class;
  logic [SITE_W-1:0] out_site;
  logic [STS_W-1:0]  out_status;
  logic              out_last;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PROB_W-1:0] ram_wdata, ram_rdata;

  logic in_accept, slot_free, out_load;
  logic site_ok, cls_ok, nb_ok, k_last;
  logic [CNT_W-1:0] ncls;
  logic signed [DIV_W-1:0] den_k, sb_sum;
  logic [CFG_W-1:0]        norm_sum;
  logic [PROB_W-1:0]       p_k;
  logic [ADDR_W-1:0] in_addr, it_addr, nb_addr, up_addr;

  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  // Range checks and saturated class count
  assign site_ok = 32'(in_site) < MAX_SITES;
  assign cls_ok  = 32'(in_cls) < MAX_CLASSES;
  assign nb_ok   = (32'(in_nb) < MAX_SITES) && (nb_total < NB_W'(MAX_NEIGHBORS));

  always_comb begin
    if (class_count < 4'd2) ncls = CNT_W'(2);
    else if (32'(class_count) > MAX_CLASSES) ncls = CNT_W'(MAX_CLASSES);
    else ncls = CNT_W'(class_count);
  end
  assign k_last = CNT_W'(k) == ncls - CNT_W'(1);

  // Store addresses
  assign in_addr = ADDR_W'(in_site) * MC_A + ADDR_W'(in_cls);
  assign it_addr = ADDR_W'(it_site) * MC_A + ADDR_W'(it_cls);
  assign nb_addr = ADDR_W'(it_nb) * MC_A + ADDR_W'(k);
  assign up_addr = ADDR_W'(it_site) * MC_A + ADDR_W'(k);

  // Per-class intermediate terms
  assign den_k = $signed(DIV_W'(costs[k])) - DIV_W'(entropy_mu) + $signed(DIV_W'(lc));
  assign sb_sum   = sb + div_rsp.quotient;
  assign p_k      = clip_prob(div_rsp.quotient);
  assign norm_sum = norm + CFG_W'(p_k);
  assign mul_b    = (state == S_UP_LC) ? SUM_W'(nb_total) : sums[k];

  // Sequencer: next state and unit controls
  always_comb begin
    state_next = state;
    s_tready   = (state == S_IDLE);
    div_req    = '0;
    ram_we     = 1'b0;
    ram_waddr  = in_addr;
    ram_wdata  = (in_prob > Q15_ONE) ? Q15_ONE : in_prob;
    ram_raddr  = it_addr;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (in_cmd)
            CMD_LOAD:     ram_we = site_ok && cls_ok;
            CMD_NEIGHBOR: if (nb_ok) state_next = S_NB_RD;
            CMD_UPDATE: begin
              if (!site_ok) state_next = S_CLEAR;
              else if (nb_total == '0) state_next = S_STAT_OUT;
              else state_next = S_UP_LC;
            end
            CMD_READ:     state_next = S_READ_RD;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_READ_RD:  state_next = S_READ_OUT;
      S_READ_OUT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_NB_RD: begin
        ram_raddr  = nb_addr;
        state_next = S_NB_ACC;
      end
      S_NB_ACC: begin
        ram_raddr  = nb_addr;
        state_next = k_last ? S_IDLE : S_NB_RD;
      end
      S_UP_LC:  state_next = S_UP_LC2;
      S_UP_LC2: state_next = S_UP_MUL;
      S_UP_MUL: state_next = S_UP_N16;
      S_UP_N16: begin
        if (k_last) state_next = (bad || den_k == '0) ? S_STAT_OUT : S_A_DIV;
        else state_next = S_UP_MUL;
      end
      S_A_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = $signed(DIV_W'(n16[k])) <<< FRAC;
        div_req.divisor  = den[k];
        state_next       = S_A_WAIT;
      end
      S_A_WAIT: if (div_rsp.done) state_next = S_B_DIV;
      S_B_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = ONE_Q38;
        div_req.divisor  = den[k];
        state_next       = S_B_WAIT;
      end
      S_B_WAIT: begin
        if (div_rsp.done) begin
          if (k_last) state_next = (sb_sum == '0) ? S_STAT_OUT : S_M_DIV;
          else state_next = S_A_DIV;
        end
      end
      S_M_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = (ONE_Q22 - sa) <<< 16;
        div_req.divisor  = sb;
        state_next       = S_M_WAIT;
      end
      S_M_WAIT: if (div_rsp.done) state_next = S_P_DIV;
      S_P_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = (m + $signed(DIV_W'(n16[k]))) <<< 15;
        div_req.divisor  = den[k];
        state_next       = S_P_WAIT;
      end
      S_P_WAIT: begin
        if (div_rsp.done) begin
          if (k_last) state_next = (norm_sum == '0) ? S_STAT_OUT : S_Q_DIV;
          else state_next = S_P_DIV;
        end
      end
      S_Q_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = $signed(DIV_W'({p[k], 15'b0}) + DIV_W'(norm >> 1));
        div_req.divisor  = $signed(DIV_W'(norm));
        state_next       = S_Q_WAIT;
      end
      S_Q_WAIT: if (div_rsp.done) state_next = S_Q_OUT;
      S_Q_OUT: begin
        ram_waddr = up_addr;
        ram_wdata = qv;
        if (slot_free) begin
          out_load   = 1'b1;
          ram_we     = 1'b1;
          state_next = k_last ? S_CLEAR : S_Q_DIV;
        end
      end
      S_STAT_OUT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = S_CLEAR;
        end
      end
      S_CLEAR: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Control state: registers, counters, sums, costs, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      lambda_gain <= 32'd65536;
      entropy_mu  <= '0;
      class_count <= 4'd2;
      k           <= '0;
      nb_total    <= '0;
      m_tvalid    <= 1'b0;
      for (int i = 0; i < MAX_CLASSES; i++) begin
        sums[i]  <= '0;
        costs[i] <= '0;
      end
    end else begin
      // Configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LAMBDA: lambda_gain <= cfg_data;
          CFG_MU:     entropy_mu  <= $signed(cfg_data);
          CFG_COUNT:  class_count <= cfg_data[3:0];
          default:    ;
        endcase
      end
      // Class cost writes
      if (in_accept && in_cmd == CMD_COST) begin
        for (int i = 0; i < MAX_CLASSES; i++) begin
          if (32'(in_cls) == i) costs[i] <= in_cost;
        end
      end
      // Class counter
      case (state) inside
        S_IDLE, S_UP_LC2, S_M_WAIT: begin
          if (state != S_M_WAIT || div_rsp.done) k <= '0;
        end
        S_NB_ACC, S_UP_N16: k <= k_last ? '0 : k + K_W'(1);
        S_B_WAIT, S_P_WAIT: if (div_rsp.done) k <= k_last ? '0 : k + K_W'(1);
        S_Q_OUT: if (slot_free && !k_last) k <= k + K_W'(1);
        default: ;
      endcase
      // Neighbor accumulation and clear
      if (state == S_NB_ACC) begin
        sums[k] <= sums[k] + SUM_W'(ram_rdata);
        if (k_last) nb_total <= nb_total + NB_W'(1);
      end
      if (state == S_CLEAR) begin
        nb_total <= '0;
        for (int i = 0; i < MAX_CLASSES; i++) sums[i] <= '0;
      end
      // Output valid
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Payload: item fields, intermediates and output register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      it_site <= in_site;
      it_cls  <= in_cls;
      it_nb   <= in_nb;
      rd_zero <= !(site_ok && cls_ok);
      status_r <= STS_NO_NB;
    end
    prod <= PROD_W'(lambda_gain) * PROD_W'(mul_b);
    case (state)
      S_UP_LC2: begin
        lc  <= prod;
        bad <= 1'b0;
      end
      S_UP_N16: begin
        n16[k] <= prod[PROD_W-1:15];
        den[k] <= den_k;
        if (den_k == '0) bad <= 1'b1;
        if (k_last && (bad || den_k == '0)) status_r <= STS_ZERO_DEN;
        sa <= '0;
        sb <= '0;
      end
      S_A_WAIT: if (div_rsp.done) sa <= sa + sat40(div_rsp.quotient);
      S_B_WAIT: begin
        if (div_rsp.done) begin
          sb <= sb_sum;
          if (k_last && sb_sum == '0) status_r <= STS_ZERO_DEN;
        end
      end
      S_M_WAIT: begin
        if (div_rsp.done) begin
          m    <= sat40(div_rsp.quotient);
          norm <= '0;
        end
      end
      S_P_WAIT: begin
        if (div_rsp.done) begin
          p[k] <= p_k;
          norm <= norm_sum;
          if (k_last && norm_sum == '0) status_r <= STS_ZERO_NORM;
        end
      end
      S_Q_WAIT: if (div_rsp.done) qv <= clip_prob(div_rsp.quotient);
      default: ;
    endcase
    if (out_load) begin
      out_site <= it_site;
      case (state)
        S_READ_OUT: begin
          out_class  <= it_cls;
          out_prob   <= rd_zero ? '0 : ram_rdata;
          out_status <= STS_OK;
          out_last   <= 1'b1;
        end
        S_Q_OUT: begin
          out_class  <= CLS_W'(k);
          out_prob   <= qv;
          out_status <= STS_OK;
          out_last   <= k_last;
        end
        default: begin
          out_class  <= '0;
          out_prob   <= '0;
          out_status <= status_r;
          out_last   <= 1'b1;
        end
      endcase
    end
  end

  assign m_tdata = {1'b0, out_prob, out_class, out_site};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  // Shared divider
  ecq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Probability store
  ecq_ram #(
    .WIDTH (PROB_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Checks
  a_nb_bound: assert property (@(posedge clk) disable iff (rst)
    nb_total <= NB_W'(MAX_NEIGHBORS))
    else $error("neighbor count above limit");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |=> nb_total == '0)
    else $error("sums not cleared after update");

  a_we_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE || state == S_Q_OUT))
    else $error("store written outside load or write-back");

endmodule

// ----- hw/rtl/ecq_ram.sv -----
// ----------------------------------------------------------------------------
// ecq_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ecq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/ecq_div.sv -----
// ----------------------------------------------------------------------------
// ecq_div: shared signed divider
// Restoring division on magnitudes, one quotient bit a cycle, quotient
// truncated toward zero. Done pulses as the last quotient bit is registered.
// ----------------------------------------------------------------------------
module ecq_div (
  input  logic             clk,
  input  logic             rst,
  input  ecq_pkg::div_req_t req,
  output ecq_pkg::div_rsp_t rsp
);
  import ecq_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] num;
  logic [DIV_W-1:0] dmag;
  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] quo;
  logic             neg;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  // Shift in the next dividend bit and trial-subtract
  assign rem_sh = {rem[DIV_W-1:0], num[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load magnitudes, then iterate
  always_ff @(posedge clk) begin
    if (req.start) begin
      num  <= req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : req.dividend;
      dmag <= req.divisor[DIV_W-1] ? DIV_W'(-req.divisor) : req.divisor;
      neg  <= req.dividend[DIV_W-1] ^ req.divisor[DIV_W-1];
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      num <= {num[DIV_W-2:0], 1'b0};
      rem <= fits ? rem_sh - {1'b0, dmag} : rem_sh;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = neg ? -$signed(quo) : $signed(quo);

endmodule
